@@ rtl/bounded_sequence_list_assert.svh @@
// assertion macros used by the bounded sequence list top level
`ifndef BOUNDED_SEQUENCE_LIST_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSL_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define BSL_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bsl_pkg.sv @@
`timescale 1ns / 1ps
// types and codes of the bounded sequence list
package bsl_pkg;

  localparam int ELEM_W = 32;

  // request kinds
  localparam logic [3:0] K_RESTART    = 4'd0;
  localparam logic [3:0] K_ADD_FRONT  = 4'd1;
  localparam logic [3:0] K_ADD_BACK   = 4'd2;
  localparam logic [3:0] K_EDIT_FRONT = 4'd3;
  localparam logic [3:0] K_EDIT_BACK  = 4'd4;
  localparam logic [3:0] K_EDIT_AT    = 4'd5;
  localparam logic [3:0] K_DEL_FRONT  = 4'd6;
  localparam logic [3:0] K_DEL_BACK   = 4'd7;
  localparam logic [3:0] K_DEL_AT     = 4'd8;
  localparam logic [3:0] K_DUMP       = 4'd9;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PEND     = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_DUMP_RD  = 6'b010000,
    S_DUMP_WR  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [ELEM_W-1:0] element;
    logic [5:0]              index;
    logic [6:0]              length;
    logic                    last;
  } res_t;

endpackage

@@ rtl/bsl_ram.sv @@
`timescale 1ns / 1ps
// element store: one write port, one read port with registered read data
module bsl_ram #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bsl_pkg::ELEM_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bsl_pkg::ELEM_W-1:0] rdata
);

  logic [bsl_pkg::ELEM_W-1:0] mem [DEPTH];
  logic [bsl_pkg::ELEM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/bounded_sequence_list.sv @@
`timescale 1ns / 1ps
// bounded sequence list top level: ring-buffer list held in a synchronous ram
//
//  channel | direction | tdata                                   | tuser       | tlast
//  --------+-----------+-----------------------------------------+-------------+------
//  in_     | sink      | value[31:0] position[39:32]             | kind[3:0]   | -
//  out_    | source    | element[31:0] index[37:32] length[44:38]| status[1:0] | last
//
//  restart, add, edit, delete front/back and unused kinds are done in the idle state, so a
//  new request can be taken every cycle while the output register drains.
//  delete at a position moves each following element with one ram read and one
//  write. dump reads each element in S_DUMP_RD and sends it from S_DUMP_WR.
//  reset clears the count and the ring head; the ram itself is not cleared.
//  a status result that meets a stalled output waits in a one-entry holding
//  register; the block takes no request until it has gone out.
module bounded_sequence_list #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[39:32]
  input  logic [3:0]  in_tuser,   // kind[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // element[31:0], element_index[37:32], length[44:38]
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_X = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_N  = CW'(DEPTH);

  function automatic logic [IW-1:0] ring_ix(input logic [IW-1:0] base,
                                            input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) begin
      s = s - DEPTH_X;
    end
    return s[IW-1:0];
  endfunction

  bsl_pkg::state_t state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] cursor_r, cursor_nxt;

  logic [3:0]                        in_kind;
  logic signed [bsl_pkg::ELEM_W-1:0] in_value;
  logic [7:0]                        in_position;
  logic                              in_acc;

  logic                       mem_we, mem_re;
  logic [IW-1:0]              mem_waddr, mem_raddr;
  logic [bsl_pkg::ELEM_W-1:0] mem_wdata, mem_rdata;

  logic          fill_full, fill_empty, pos_ok;
  logic [IW-1:0] at_ix, head_inc, head_dec;
  logic          at_is_last, shift_done, dump_last;
  logic          stat_go, dump_go, out_free;
  logic [1:0]    stat_code;

  logic             out_valid_r;
  bsl_pkg::res_t    out_r;
  logic [1:0]       pend_status_r;
  logic [CW-1:0]    pend_length_r;

  assign in_kind     = in_tuser;
  assign in_value    = in_tdata[31:0];
  assign in_position = in_tdata[39:32];
  assign in_tready   = (state_r == bsl_pkg::S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;

  assign fill_full  = (fill_r == FULL_N);
  assign fill_empty = (fill_r == '0);
  assign pos_ok     = (in_position != 8'd0) && (in_position <= 8'(fill_r));
  assign at_ix      = IW'(in_position - 8'd1);
  assign at_is_last = (CW'(at_ix) + CW'(1)) == fill_r;
  assign head_inc   = (head_r == LAST_IX) ? '0 : head_r + IW'(1);
  assign head_dec   = (head_r == '0) ? LAST_IX : head_r - IW'(1);
  assign shift_done = (CW'(cursor_r) + CW'(2)) == fill_r;
  assign dump_last  = (CW'(cursor_r) + CW'(1)) == fill_r;

  bsl_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    fill_nxt   = fill_r;
    cursor_nxt = cursor_r;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = in_value;
    mem_re     = 1'b0;
    mem_raddr  = head_r;
    stat_go    = 1'b0;
    stat_code  = bsl_pkg::ST_OK;
    dump_go    = 1'b0;

    unique case (state_r)
      bsl_pkg::S_IDLE: begin
        if (in_acc) begin
          unique case (in_kind) inside
            bsl_pkg::K_RESTART: begin
              mem_we   = 1'b1;
              fill_nxt = CW'(1);
              stat_go  = 1'b1;
            end
            bsl_pkg::K_ADD_FRONT, bsl_pkg::K_ADD_BACK: begin
              stat_go = 1'b1;
              if (fill_full) begin
                stat_code = bsl_pkg::ST_FULL;
              end else begin
                mem_we   = 1'b1;
                fill_nxt = fill_r + CW'(1);
                if (in_kind == bsl_pkg::K_ADD_FRONT) begin
                  head_nxt  = head_dec;
                  mem_waddr = head_dec;
                end else begin
                  mem_waddr = ring_ix(head_r, IW'(fill_r));
                end
              end
            end
            [bsl_pkg::K_EDIT_FRONT:bsl_pkg::K_DEL_AT]: begin
              stat_go = 1'b1;
              if (fill_empty) begin
                stat_code = bsl_pkg::ST_EMPTY;
              end else if ((in_kind == bsl_pkg::K_EDIT_AT || in_kind == bsl_pkg::K_DEL_AT)
                           && !pos_ok) begin
                stat_code = bsl_pkg::ST_RANGE;
              end else begin
                unique case (in_kind)
                  bsl_pkg::K_EDIT_FRONT: begin
                    mem_we = 1'b1;
                  end
                  bsl_pkg::K_EDIT_BACK: begin
                    mem_we    = 1'b1;
                    mem_waddr = ring_ix(head_r, IW'(fill_r - CW'(1)));
                  end
                  bsl_pkg::K_EDIT_AT: begin
                    mem_we    = 1'b1;
                    mem_waddr = ring_ix(head_r, at_ix);
                  end
                  bsl_pkg::K_DEL_FRONT: begin
                    head_nxt = head_inc;
                    fill_nxt = fill_r - CW'(1);
                  end
                  bsl_pkg::K_DEL_BACK: begin
                    fill_nxt = fill_r - CW'(1);
                  end
                  default: begin
                    // delete at a position: close the gap unless it is the back
                    if (at_is_last) begin
                      fill_nxt = fill_r - CW'(1);
                    end else begin
                      stat_go    = 1'b0;
                      cursor_nxt = at_ix;
                      state_nxt  = bsl_pkg::S_SHIFT_RD;
                    end
                  end
                endcase
              end
            end
            bsl_pkg::K_DUMP: begin
              if (fill_empty) begin
                stat_go   = 1'b1;
                stat_code = bsl_pkg::ST_EMPTY;
              end else begin
                cursor_nxt = '0;
                state_nxt  = bsl_pkg::S_DUMP_RD;
              end
            end
            default: begin
              stat_go = 1'b1;
            end
          endcase
        end
      end
      bsl_pkg::S_PEND: begin
        if (out_free) begin
          state_nxt = bsl_pkg::S_IDLE;
        end
      end
      bsl_pkg::S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ring_ix(head_r, cursor_r + IW'(1));
        state_nxt = bsl_pkg::S_SHIFT_WR;
      end
      bsl_pkg::S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ring_ix(head_r, cursor_r);
        mem_wdata = mem_rdata;
        if (shift_done) begin
          fill_nxt = fill_r - CW'(1);
          stat_go  = 1'b1;
        end else begin
          cursor_nxt = cursor_r + IW'(1);
          state_nxt  = bsl_pkg::S_SHIFT_RD;
        end
      end
      bsl_pkg::S_DUMP_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ring_ix(head_r, cursor_r);
        state_nxt = bsl_pkg::S_DUMP_WR;
      end
      bsl_pkg::S_DUMP_WR: begin
        if (out_free) begin
          dump_go = 1'b1;
          if (dump_last) begin
            state_nxt = bsl_pkg::S_IDLE;
          end else begin
            cursor_nxt = cursor_r + IW'(1);
            state_nxt  = bsl_pkg::S_DUMP_RD;
          end
        end
      end
      default: begin
        state_nxt = bsl_pkg::S_IDLE;
      end
    endcase

    // a status result that finds the output busy is parked
    if (stat_go) begin
      state_nxt = out_free ? bsl_pkg::S_IDLE : bsl_pkg::S_PEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsl_pkg::S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      cursor_r <= cursor_nxt;
      if ((stat_go && out_free) || (state_r == bsl_pkg::S_PEND && out_free) || dump_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat_go && out_free) begin
      out_r.status  <= stat_code;
      out_r.element <= '0;
      out_r.index   <= '0;
      out_r.length  <= 7'(fill_nxt);
      out_r.last    <= 1'b1;
    end else if (state_r == bsl_pkg::S_PEND && out_free) begin
      out_r.status  <= pend_status_r;
      out_r.element <= '0;
      out_r.index   <= '0;
      out_r.length  <= 7'(pend_length_r);
      out_r.last    <= 1'b1;
    end else if (dump_go) begin
      out_r.status  <= bsl_pkg::ST_OK;
      out_r.element <= mem_rdata;
      out_r.index   <= 6'(cursor_r);
      out_r.length  <= 7'(fill_r);
      out_r.last    <= dump_last;
    end
    if (stat_go && !out_free) begin
      pend_status_r <= stat_code;
      pend_length_r <= fill_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r.length, out_r.index, out_r.element};
  assign out_tuser  = out_r.status;
  assign out_tlast  = out_r.last;

`include "bounded_sequence_list_assert.svh"

  `BSL_NEXT(a_full_add_keeps, in_acc && fill_full && (in_kind == bsl_pkg::K_ADD_FRONT || in_kind == bsl_pkg::K_ADD_BACK), fill_r == $past(fill_r) && head_r == $past(head_r), "add to a full list changed the list")
  `BSL_NEXT(a_shift_end_count, state_r == bsl_pkg::S_SHIFT_WR && shift_done, fill_r == $past(fill_r) - CW'(1), "gap close did not drop the count by one")
  `BSL_HOLDS(a_pend_output_busy, state_r == bsl_pkg::S_PEND, out_valid_r, "held status without a busy output register")

endmodule
